// ----- rtl/palette_two_colour_mix_select_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef PALETTE_TWO_COLOUR_MIX_SELECT_TOP_DEFINES_SVH
`define PALETTE_TWO_COLOUR_MIX_SELECT_TOP_DEFINES_SVH

// Same-cycle implication.
`define PTCMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PTCMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ptcms_pkg.sv -----
package ptcms_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   function automatic logic [7:0] chan_sel(rgb_type c, logic [1:0] k);
      logic [7:0] v;
      case (k)
         CH_RED:   v = c.red;
         CH_GREEN: v = c.green;
         default:  v = c.blue;
      endcase
      return v;
   endfunction

   function automatic logic signed [8:0] chan_diff(logic [7:0] x, logic [7:0] y);
      return $signed({1'b0, x}) - $signed({1'b0, y});
   endfunction

endpackage

// ----- rtl/palette_two_colour_mix_select_top.sv -----
// Palette two-colour mix select.
// Input channel (req_*): operation load writes req_entry_index with the RGB value;
// operation query looks up a pixel. Every accepted item gives exactly one result.
// Result channel (rsp_*): mixed colour, first and second pick, blend weight in 1/256.
// Loads return all-zero fields. csr_* writes palette_count (entries in use).
// One item is worked at a time; req_stall is high from acceptance until the result
// moves into the output register. All arithmetic runs through one multiply-accumulate
// unit, one colour channel per cycle, plus a one-bit-per-cycle restoring divider.
// Sequence, acceptance to result valid, with N entries in use: a load goes straight
// to the output register. A query runs a first scan over the N entries, then a
// second scan with a dot product on each candidate move (entry 0 included); the
// scan ends early once the candidate lies beyond the first pick. When both picks
// agree, the first pick's colour is the result; else the dot products for the
// weight, 11 divide steps and the mix follow.
// Reset clears the control and sets palette_count to 16; palette contents are
// undefined until loaded. When the receiver stalls, the result holds in the output
// register; the next item is still accepted and worked, and waits for the output.
module palette_two_colour_mix_select_top #(
   parameter int PALETTE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [3:0]         req_entry_index,
   input  logic [7:0]         req_red_in,
   input  logic [7:0]         req_green_in,
   input  logic [7:0]         req_blue_in,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_red_out,
   output logic [7:0]         rsp_green_out,
   output logic [7:0]         rsp_blue_out,
   output logic [3:0]         rsp_first_pick,
   output logic [3:0]         rsp_second_pick,
   output logic signed [10:0] rsp_blend_weight,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int AddrWidth = $clog2(PALETTE_DEPTH);
   localparam int UsedMax   = (PALETTE_DEPTH < 16) ? PALETTE_DEPTH : 16;
   localparam logic [4:0] UsedMaxCount = 5'(UsedMax);
   localparam logic [4:0] CountReset   = 5'd16;
   localparam logic       REG_PALETTE_COUNT = 1'b0;

   localparam logic signed [10:0] WeightMax = 11'sh3FF;
   localparam logic signed [10:0] WeightMin = 11'sh400;
   localparam logic [3:0]         QuoLastBit = 4'd10;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_S1_WAIT = 4'd1;
   localparam logic [3:0] S_S1_MAC  = 4'd2;
   localparam logic [3:0] S_S2_WAIT = 4'd3;
   localparam logic [3:0] S_S2_DIST = 4'd4;
   localparam logic [3:0] S_S2_DOT  = 4'd5;
   localparam logic [3:0] S_PICK    = 4'd6;
   localparam logic [3:0] S_NUM     = 4'd7;
   localparam logic [3:0] S_DEN     = 4'd8;
   localparam logic [3:0] S_PREP    = 4'd9;
   localparam logic [3:0] S_CHK     = 4'd10;
   localparam logic [3:0] S_DIV     = 4'd11;
   localparam logic [3:0] S_SAT     = 4'd12;
   localparam logic [3:0] S_MIX     = 4'd13;
   localparam logic [3:0] S_FINISH  = 4'd14;

   logic [3:0]              state_ff, state_in;
   logic [3:0]              e_ff, e_in;
   logic [1:0]              k_ff, k_in;
   logic signed [21:0]      acc_ff, acc_in;
   ptcms_pkg::rgb_type      pixel_ff, pixel_in;
   ptcms_pkg::rgb_type      first_col_ff, first_col_in;
   ptcms_pkg::rgb_type      second_col_ff, second_col_in;
   logic [3:0]              first_ff, first_in;
   logic [3:0]              second_ff, second_in;
   logic [17:0]             best_ff, best_in;
   logic [17:0]             cand_dist_ff, cand_dist_in;
   logic signed [18:0]      num_ff, num_in;
   logic [17:0]             den_ff, den_in;
   logic [27:0]             rem_ff, rem_in;
   logic [29:0]             dsh_ff, dsh_in;
   logic                    neg_ff, neg_in;
   logic [10:0]             quo_ff, quo_in;
   logic [3:0]              bit_ff, bit_in;
   logic signed [10:0]      tq_ff, tq_in;
   ptcms_pkg::rgb_type      mix_ff, mix_in;
   logic [4:0]              count_ff, count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   ptcms_pkg::rgb_type      rsp_col_ff;
   logic [3:0]              rsp_first_ff;
   logic [3:0]              rsp_second_ff;
   logic signed [10:0]      rsp_weight_ff;

   logic [4:0]              used_count;
   logic [3:0]              last_idx;
   logic                    ram_wr_en;
   logic                    idx_in_range;
   logic [23:0]             ram_rd_data;
   ptcms_pkg::rgb_type      rd_col;
   ptcms_pkg::rgb_type      req_pixel;

   logic [7:0]              ch_mem, ch_pix, ch_a, ch_b;
   logic signed [8:0]       diff_mp, diff_ma, diff_ap, diff_ba, diff_pa;
   logic signed [10:0]      op_x;
   logic signed [9:0]       op_y;
   logic signed [20:0]      mac_prod;
   logic signed [21:0]      mac_sum;
   logic                    dot_pos;

   logic signed [28:0]      n_val;
   logic [18:0]             d_val;
   logic signed [28:0]      u_val;
   logic                    div_ovf;
   logic                    div_ge;

   logic signed [21:0]      mix_round;
   logic signed [21:0]      mix_val;
   logic [7:0]              mix_chan;

   logic                    out_free;
   logic                    rsp_load;
   logic                    csr_write;

   assign req_pixel = '{red: req_red_in, green: req_green_in, blue: req_blue_in};
   assign idx_in_range = 32'(req_entry_index) < 32'(PALETTE_DEPTH);
   assign rd_col = ptcms_pkg::rgb_type'(ram_rd_data);

   ptcms_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AddrWidth'(req_entry_index)),
      .wr_data (req_pixel),
      .rd_addr (AddrWidth'(e_ff)),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      used_count = count_ff;
      if (used_count == 5'd0) begin
         used_count = 5'd1;
      end
      if (used_count > UsedMaxCount) begin
         used_count = UsedMaxCount;
      end
      last_idx = 4'(used_count - 5'd1);
   end

   // shared multiply-accumulate operands
   always_comb begin
      ch_mem  = ptcms_pkg::chan_sel(rd_col, k_ff);
      ch_pix  = ptcms_pkg::chan_sel(pixel_ff, k_ff);
      ch_a    = ptcms_pkg::chan_sel(first_col_ff, k_ff);
      ch_b    = ptcms_pkg::chan_sel(second_col_ff, k_ff);
      diff_mp = ptcms_pkg::chan_diff(ch_mem, ch_pix);
      diff_ma = ptcms_pkg::chan_diff(ch_mem, ch_a);
      diff_ap = ptcms_pkg::chan_diff(ch_a, ch_pix);
      diff_ba = ptcms_pkg::chan_diff(ch_b, ch_a);
      diff_pa = ptcms_pkg::chan_diff(ch_pix, ch_a);
      case (state_ff)
         S_S1_MAC, S_S2_DIST: begin
            op_x = 11'(diff_mp);
            op_y = 10'(diff_mp);
         end
         S_S2_DOT: begin
            op_x = 11'(diff_ma);
            op_y = 10'(diff_ap);
         end
         S_NUM: begin
            op_x = 11'(diff_ba);
            op_y = 10'(diff_pa);
         end
         S_DEN: begin
            op_x = 11'(diff_ba);
            op_y = 10'(diff_ba);
         end
         S_MIX: begin
            op_x = tq_ff;
            op_y = 10'(diff_ba);
         end
         default: begin
            op_x = '0;
            op_y = '0;
         end
      endcase
      mac_prod = op_x * op_y;
      mac_sum  = acc_ff + 22'(mac_prod);
      dot_pos  = !mac_sum[21] && (mac_sum != '0);
   end

   // divider setup and steps
   always_comb begin
      n_val   = (29'(num_ff) <<< 9) + $signed({11'd0, den_ff});
      d_val   = {den_ff, 1'b0};
      u_val   = n_val[28] ? (~n_val) + $signed({10'd0, d_val}) : n_val;
      div_ovf = {3'd0, rem_ff} >= {dsh_ff, 1'b0};
      div_ge  = {2'd0, rem_ff} >= dsh_ff;
   end

   // mix: a + floor((t * (b - a) + 128) / 256), saturated
   always_comb begin
      mix_round = (22'(mac_prod) + 22'sd128) >>> 8;
      mix_val   = mix_round + $signed({14'd0, ch_a});
      if (mix_val[21]) begin
         mix_chan = 8'd0;
      end else if (mix_val > 22'sd255) begin
         mix_chan = 8'd255;
      end else begin
         mix_chan = mix_val[7:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      e_in          = e_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      pixel_in      = pixel_ff;
      first_col_in  = first_col_ff;
      second_col_in = second_col_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      best_in       = best_ff;
      cand_dist_in  = cand_dist_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      neg_in        = neg_ff;
      quo_in        = quo_ff;
      bit_in        = bit_ff;
      tq_in         = tq_ff;
      mix_in        = mix_ff;
      ram_wr_en     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == ptcms_pkg::OP_LOAD) begin
                  ram_wr_en = idx_in_range;
                  mix_in    = '0;
                  first_in  = '0;
                  second_in = '0;
                  tq_in     = '0;
                  state_in  = S_FINISH;
               end else begin
                  pixel_in = req_pixel;
                  e_in     = '0;
                  state_in = S_S1_WAIT;
               end
            end
         end
         S_S1_WAIT: begin
            acc_in   = '0;
            k_in     = ptcms_pkg::CH_RED;
            state_in = S_S1_MAC;
         end
         S_S1_MAC: begin
            acc_in = mac_sum;
            k_in   = k_ff + 2'd1;
            if (k_ff == ptcms_pkg::CH_BLUE) begin
               if ((e_ff == '0) || (mac_sum[17:0] < best_ff)) begin
                  best_in      = mac_sum[17:0];
                  first_in     = e_ff;
                  first_col_in = rd_col;
               end
               if (e_ff == last_idx) begin
                  e_in     = '0;
                  state_in = S_S2_WAIT;
               end else begin
                  e_in     = e_ff + 4'd1;
                  state_in = S_S1_WAIT;
               end
            end
         end
         S_S2_WAIT: begin
            acc_in   = '0;
            k_in     = ptcms_pkg::CH_RED;
            state_in = S_S2_DIST;
         end
         S_S2_DIST: begin
            acc_in = mac_sum;
            k_in   = k_ff + 2'd1;
            if (k_ff == ptcms_pkg::CH_BLUE) begin
               if ((e_ff == '0) || (mac_sum[17:0] < cand_dist_ff)) begin
                  cand_dist_in  = mac_sum[17:0];
                  second_in     = e_ff;
                  second_col_in = rd_col;
                  acc_in        = '0;
                  k_in          = ptcms_pkg::CH_RED;
                  state_in      = S_S2_DOT;
               end else if (e_ff == last_idx) begin
                  state_in = S_PICK;
               end else begin
                  e_in     = e_ff + 4'd1;
                  state_in = S_S2_WAIT;
               end
            end
         end
         S_S2_DOT: begin
            acc_in = mac_sum;
            k_in   = k_ff + 2'd1;
            if (k_ff == ptcms_pkg::CH_BLUE) begin
               // candidate beyond the first pick never moves again
               if (dot_pos || (e_ff == last_idx)) begin
                  state_in = S_PICK;
               end else begin
                  e_in     = e_ff + 4'd1;
                  state_in = S_S2_WAIT;
               end
            end
         end
         S_PICK: begin
            acc_in = '0;
            k_in   = ptcms_pkg::CH_RED;
            if (first_ff == second_ff) begin
               mix_in   = first_col_ff;
               tq_in    = '0;
               state_in = S_FINISH;
            end else begin
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            acc_in = mac_sum;
            k_in   = k_ff + 2'd1;
            if (k_ff == ptcms_pkg::CH_BLUE) begin
               num_in   = mac_sum[18:0];
               acc_in   = '0;
               k_in     = ptcms_pkg::CH_RED;
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            acc_in = mac_sum;
            k_in   = k_ff + 2'd1;
            if (k_ff == ptcms_pkg::CH_BLUE) begin
               den_in   = mac_sum[17:0];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (den_ff == '0) begin
               tq_in    = '0;
               k_in     = ptcms_pkg::CH_RED;
               state_in = S_MIX;
            end else begin
               rem_in   = u_val[27:0];
               dsh_in   = {1'b0, d_val, 10'd0};
               neg_in   = n_val[28];
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (div_ovf) begin
               tq_in    = neg_ff ? WeightMin : WeightMax;
               k_in     = ptcms_pkg::CH_RED;
               state_in = S_MIX;
            end else begin
               quo_in   = '0;
               bit_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - dsh_ff[27:0];
            end
            quo_in = {quo_ff[9:0], div_ge};
            dsh_in = dsh_ff >> 1;
            bit_in = bit_ff + 4'd1;
            if (bit_ff == QuoLastBit) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            if (neg_ff) begin
               tq_in = (quo_ff > 11'd1024) ? WeightMin : $signed(~quo_ff + 11'd1);
            end else begin
               tq_in = quo_ff[10] ? WeightMax : $signed(quo_ff);
            end
            k_in     = ptcms_pkg::CH_RED;
            state_in = S_MIX;
         end
         S_MIX: begin
            k_in = k_ff + 2'd1;
            case (k_ff)
               ptcms_pkg::CH_RED:   mix_in.red   = mix_chan;
               ptcms_pkg::CH_GREEN: mix_in.green = mix_chan;
               default:             mix_in.blue  = mix_chan;
            endcase
            if (k_ff == ptcms_pkg::CH_BLUE) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_load     = (state_ff == S_FINISH) && out_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff          <= e_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      pixel_ff      <= pixel_in;
      first_col_ff  <= first_col_in;
      second_col_ff <= second_col_in;
      first_ff      <= first_in;
      second_ff     <= second_in;
      best_ff       <= best_in;
      cand_dist_ff  <= cand_dist_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      dsh_ff        <= dsh_in;
      neg_ff        <= neg_in;
      quo_ff        <= quo_in;
      bit_ff        <= bit_in;
      tq_ff         <= tq_in;
      mix_ff        <= mix_in;
      if (rsp_load) begin
         rsp_col_ff    <= mix_ff;
         rsp_first_ff  <= first_ff;
         rsp_second_ff <= second_ff;
         rsp_weight_ff <= tq_ff;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_out      = rsp_col_ff.red;
   assign rsp_green_out    = rsp_col_ff.green;
   assign rsp_blue_out     = rsp_col_ff.blue;
   assign rsp_first_pick   = rsp_first_ff;
   assign rsp_second_pick  = rsp_second_ff;
   assign rsp_blend_weight = rsp_weight_ff;

   // register file
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      count_in = count_ff;
      if (csr_write && (csr_paddr[2] == REG_PALETTE_COUNT)) begin
         count_in = csr_pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountReset;
      end else begin
         count_ff <= count_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_PALETTE_COUNT) ? {27'd0, count_ff} : 32'd0;

endmodule

// ----- rtl/ptcms_ram.sv -----
module ptcms_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ptcms_checker.sv -----
`include "palette_two_colour_mix_select_top_defines.svh"

module ptcms_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_operation,
   input logic [3:0]         req_entry_index,
   input logic [7:0]         req_red_in,
   input logic [7:0]         req_green_in,
   input logic [7:0]         req_blue_in,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [7:0]         rsp_red_out,
   input logic [7:0]         rsp_green_out,
   input logic [7:0]         rsp_blue_out,
   input logic [3:0]         rsp_first_pick,
   input logic [3:0]         rsp_second_pick,
   input logic signed [10:0] rsp_blend_weight,
   input logic               csr_psel,
   input logic               csr_penable,
   input logic               csr_pwrite,
   input logic [2:0]         csr_paddr,
   input logic [31:0]        csr_pwdata,
   input logic [31:0]        csr_prdata,
   input logic               csr_pready
);

   `PTCMS_ASSERT_NOW(a_equal_picks_no_weight, rsp_valid && (rsp_first_pick == rsp_second_pick), rsp_blend_weight == 11'sd0, "equal picks with nonzero weight")
   `PTCMS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "item accepted while previous one in work")
   `PTCMS_ASSERT_NEXT(a_no_instant_result, req_valid && !req_stall && !rsp_valid, !rsp_valid, "result one cycle after acceptance")
   `PTCMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_blend_weight), "stalled result changed")

endmodule

bind palette_two_colour_mix_select_top ptcms_checker u_ptcms_checker (.*);
